### rtl/bfknn_pkg.sv
// bfknn_pkg: shared types and constants for the brute-force knn search block
// no dependencies
package bfknn_pkg;

    localparam int STORE_DEPTH   = 1024;
    localparam int MAX_NEIGHBORS = 16;
    localparam int COORD_BITS    = 16;
    localparam int DIMS          = 3;

    localparam int IDX_W   = $clog2(STORE_DEPTH);
    localparam int NUM_W   = IDX_W + 1;
    localparam int K_W     = $clog2(MAX_NEIGHBORS);
    localparam int KCNT_W  = K_W + 1;
    localparam int SUM_W   = COORD_BITS + 2;
    localparam int DIST_W  = 36;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        METRIC_MOD_MANHATTAN = 2'd0,
        METRIC_EUCLIDEAN     = 2'd1,
        METRIC_MANHATTAN     = 2'd2,
        METRIC_MANHATTAN_ALT = 2'd3
    } metric_t;

    localparam logic [1:0] CFG_METRIC    = 2'd0;
    localparam logic [1:0] CFG_NEIGHBORS = 2'd1;
    localparam logic [1:0] CFG_NUM_REF   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // queued command from front to back
    typedef struct packed {
        logic                  op;
        logic [IDX_W-1:0]      load_addr;
        logic [9:0]            query_id;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } cmd_t;

endpackage

### rtl/bfknn_front.sv
// bfknn_front: input beat acceptance into a two-entry command queue
// depends on bfknn_pkg
module bfknn_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bfknn_pkg::cmd_t   in_cmd,
    output logic              q_valid,
    output bfknn_pkg::cmd_t   q_cmd,
    input  logic              q_take
);
    import bfknn_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ q_take;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end

endmodule

### rtl/bfknn_back.sv
// bfknn_back: reference store, per-point distance pipeline, top-k insertion list
// depends on bfknn_pkg
module bfknn_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  bfknn_pkg::cmd_t               q_cmd,
    output logic                          q_take,
    input  logic [1:0]                    metric,
    input  logic [4:0]                    neighbor_count,
    input  logic [10:0]                   num_ref,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [9:0]                    neighbor_index,
    output logic [3:0]                    rank,
    output logic [9:0]                    result_tag,
    output logic                          last
);
    import bfknn_pkg::*;

    logic [3*COORD_BITS-1:0] store [STORE_DEPTH];

    state_t state_reg, state_next;
    cmd_t   cur_reg;
    logic [NUM_W-1:0]  n_reg;
    logic [KCNT_W-1:0] k_reg;
    logic [NUM_W-1:0]  addr_reg;
    logic [KCNT_W-1:0] emit_reg;
    logic [1:0]        drain_reg;

    logic [DIST_W-1:0] best_d [MAX_NEIGHBORS];
    logic [IDX_W-1:0]  best_i [MAX_NEIGHBORS];

    // stage 1: store read
    logic              s1_v;
    logic [IDX_W-1:0]  s1_idx;
    logic [3*COORD_BITS-1:0] s1_pt;
    // stage 2: per-coordinate absolute differences or squares, and the coordinate-sum difference
    logic              s2_v;
    logic [IDX_W-1:0]  s2_idx;
    logic [2*COORD_BITS+1:0] s2_t [3];
    logic [SUM_W:0]    s2_mod;
    // stage 3: distance
    logic              s3_v;
    logic [IDX_W-1:0]  s3_idx;
    logic [DIST_W-1:0] s3_d;

    logic            out_v_reg;
    logic [9:0]      oi_reg, ot_reg;
    logic [3:0]      or_reg;
    logic            ol_reg;

    logic [NUM_W-1:0]  n_sat;
    logic [KCNT_W-1:0] k_sat;
    logic              out_free;
    logic              is_load;

    assign out_free = !out_v_reg || !out_stall;
    assign is_load  = (q_cmd.op == OP_LOAD);

    always_comb
    begin
        n_sat = (num_ref > 11'(STORE_DEPTH)) ? NUM_W'(STORE_DEPTH) : NUM_W'(num_ref);
        k_sat = (neighbor_count > 5'(MAX_NEIGHBORS)) ? KCNT_W'(MAX_NEIGHBORS)
                                                     : KCNT_W'(neighbor_count);
        if ({{(NUM_W-KCNT_W){1'b0}}, k_sat} > n_sat)
            k_sat = KCNT_W'(n_sat);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid && !is_load)
                    state_next = (k_sat == '0) ? ST_IDLE : ST_SCAN;
            ST_SCAN:
                if (addr_reg == n_reg - 1'b1)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (drain_reg == 2'd3)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free && emit_reg == k_reg - 1'b1)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_take = (state_reg == ST_IDLE) && q_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            emit_reg  <= '0;
            drain_reg <= '0;
            s1_v      <= 1'b0;
            s2_v      <= 1'b0;
            s3_v      <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v      <= (state_reg == ST_SCAN);
            s2_v      <= s1_v;
            s3_v      <= s2_v;
            if (state_reg == ST_EMIT && out_free)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    addr_reg  <= '0;
                    emit_reg  <= '0;
                    drain_reg <= '0;
                end
                ST_SCAN:
                    addr_reg <= addr_reg + 1'b1;
                ST_DRAIN:
                    drain_reg <= drain_reg + 1'b1;
                ST_EMIT:
                    if (out_free)
                        emit_reg <= emit_reg + 1'b1;
                default:
                    addr_reg <= '0;
            endcase
        end
    end

    // payload and datapath
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            cur_reg <= q_cmd;
            n_reg   <= n_sat;
            k_reg   <= k_sat;
            if (is_load)
                store[q_cmd.load_addr] <= {q_cmd.z, q_cmd.y, q_cmd.x};
        end
        s1_idx <= addr_reg[IDX_W-1:0];
        s1_pt  <= store[addr_reg[IDX_W-1:0]];
        if (state_reg == ST_EMIT && out_free)
        begin
            oi_reg <= 10'(best_i[emit_reg[K_W-1:0]]);
            or_reg <= 4'(emit_reg);
            ot_reg <= cur_reg.query_id;
            ol_reg <= (emit_reg == k_reg - 1'b1);
        end
    end

    // per-coordinate terms and the absolute difference of the coordinate sums
    always_ff @(posedge clk)
    begin
        logic signed [COORD_BITS:0] df;
        logic [COORD_BITS:0]        ad;
        logic signed [SUM_W-1:0]    sq, sr;
        logic signed [SUM_W:0]      sd;
        sq = $signed(cur_reg.x) + $signed(cur_reg.y) + $signed(cur_reg.z);
        sr = $signed(s1_pt[COORD_BITS-1:0]) + $signed(s1_pt[2*COORD_BITS-1:COORD_BITS])
           + $signed(s1_pt[3*COORD_BITS-1:2*COORD_BITS]);
        sd = {sq[SUM_W-1], sq} - {sr[SUM_W-1], sr};
        s2_mod <= sd[SUM_W] ? (SUM_W+1)'(0) - sd : sd;
        s2_idx <= s1_idx;
        for (int d = 0; d < 3; d++)
        begin
            case (d)
                0: df = $signed({cur_reg.x[COORD_BITS-1], cur_reg.x})
                      - $signed({s1_pt[COORD_BITS-1], s1_pt[COORD_BITS-1:0]});
                1: df = $signed({cur_reg.y[COORD_BITS-1], cur_reg.y})
                      - $signed({s1_pt[2*COORD_BITS-1], s1_pt[2*COORD_BITS-1:COORD_BITS]});
                default: df = $signed({cur_reg.z[COORD_BITS-1], cur_reg.z})
                      - $signed({s1_pt[3*COORD_BITS-1],
                                 s1_pt[3*COORD_BITS-1:2*COORD_BITS]});
            endcase
            ad = df[COORD_BITS] ? (COORD_BITS+1)'(0) - df : df;
            if (metric == METRIC_EUCLIDEAN)
                s2_t[d] <= ad * ad;
            else
                s2_t[d] <= (2*COORD_BITS+2)'(ad);
        end
    end

    always_ff @(posedge clk)
    begin
        s3_idx <= s2_idx;
        if (metric == METRIC_MOD_MANHATTAN)
            s3_d <= DIST_W'(s2_mod);
        else
            s3_d <= DIST_W'(s2_t[0]) + DIST_W'(s2_t[1]) + DIST_W'(s2_t[2]);
    end

    // insertion list: entries at or below new distance stay, the rest shift down
    always_ff @(posedge clk)
    begin
        logic [MAX_NEIGHBORS-1:0] gt;
        if (q_take)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                best_d[j] <= DIST_MAX;
                best_i[j] <= '0;
            end
        end
        else if (s3_v)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
                gt[j] = (best_d[j] > s3_d);
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                if (KCNT_W'(j) < k_reg && gt[j])
                begin
                    if (j == 0 || !gt[(j == 0) ? 0 : j-1])
                    begin
                        best_d[j] <= s3_d;
                        best_i[j] <= s3_idx;
                    end
                    else
                    begin
                        best_d[j] <= best_d[(j == 0) ? 0 : j-1];
                        best_i[j] <= best_i[(j == 0) ? 0 : j-1];
                    end
                end
            end
        end
    end

    assign out_valid      = out_v_reg;
    assign neighbor_index = oi_reg;
    assign rank           = or_reg;
    assign result_tag     = ot_reg;
    assign last           = ol_reg;

endmodule

### rtl/brute_force_knn_search.sv
// brute_force_knn_search: top level, config registers plus front queue and back engine
// depends on bfknn_pkg, bfknn_front, bfknn_back
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | operation load_addr query_id coord_x/y/z
//  out     | output    | out_valid/out_stall| neighbor_index rank result_tag last
//  cfg     | input     | cfg_we             | cfg_index cfg_data
//
// a load is written into the store when the back engine takes it; a query scans num_ref
// stored points (one stored point per cycle, set by the single store read port), then emits k beats
// rst_n clears control only; the reference store holds garbage until loaded
// a stalled output beat holds; the two-entry queue keeps taking beats meanwhile until it is full
module brute_force_knn_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [9:0]  load_addr,
    input  logic [9:0]  query_id,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] coord_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  neighbor_index,
    output logic [3:0]  rank,
    output logic [9:0]  result_tag,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import bfknn_pkg::*;

    logic [1:0]  metric_reg;
    logic [4:0]  k_reg;
    logic [10:0] num_reg;
    cmd_t        in_cmd, q_cmd;
    logic        q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_EUCLIDEAN;
            k_reg      <= 5'd1;
            num_reg    <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_METRIC:    metric_reg <= cfg_data[1:0];
                CFG_NEIGHBORS: k_reg      <= cfg_data[4:0];
                CFG_NUM_REF:   num_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        in_cmd.op          = operation;
        in_cmd.load_addr   = load_addr;
        in_cmd.query_id    = query_id;
        in_cmd.x           = coord_x;
        in_cmd.y           = coord_y;
        in_cmd.z           = coord_z;
    end

    bfknn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_take   (q_take)
    );

    bfknn_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_take         (q_take),
        .metric         (metric_reg),
        .neighbor_count (k_reg),
        .num_ref        (num_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .neighbor_index (neighbor_index),
        .rank           (rank),
        .result_tag     (result_tag),
        .last           (last)
    );

endmodule

### rtl/bfknn_checker.sv
// bfknn_checker: port-level assertions for brute_force_knn_search
// depends on the top level's ports only
module bfknn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [9:0] neighbor_index,
    input logic [3:0] rank,
    input logic [9:0] result_tag,
    input logic       last
);
    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(neighbor_index) && $stable(rank))
        else $error("stalled output beat changed");

    // rank advances by one within a query
    a_rank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last ##1 out_valid |-> rank == $past(rank) + 4'd1)
        else $error("rank did not advance");

    // a new query starts at rank zero
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last ##1 out_valid |-> rank == 4'd0)
        else $error("query did not start at rank zero");

    // tag is constant within a query
    a_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last ##1 out_valid |-> $stable(result_tag))
        else $error("tag changed within a query");

endmodule

bind brute_force_knn_search bfknn_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .neighbor_index (neighbor_index),
    .rank           (rank),
    .result_tag     (result_tag),
    .last           (last)
);

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for brute_force_knn_search
// depends on bfknn_pkg and the brute_force_knn_search rtl; predicts results internally
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bfknn_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [9:0]  load_addr;
    logic [9:0]  query_id;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  neighbor_index;
    logic [3:0]  rank;
    logic [9:0]  result_tag;
    logic        last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    typedef struct packed {
        logic [9:0] nbr;
        logic [3:0] rnk;
        logic [9:0] tag;
        logic       lst;
    } nbr_beat_t;

    // predictor state
    logic signed [15:0] pts_x [STORE_DEPTH];
    logic signed [15:0] pts_y [STORE_DEPTH];
    logic signed [15:0] pts_z [STORE_DEPTH];
    logic [1:0]         cur_metric;
    logic [4:0]         cur_k;
    logic [10:0]        cur_nref;

    nbr_beat_t expected_beats[$];
    int        error_count;
    bit        no_idle;

    brute_force_knn_search u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic logic [35:0] point_distance(input int q, input logic signed [15:0] qx,
                                                   input logic signed [15:0] qy,
                                                   input logic signed [15:0] qz);
        longint dx;
        longint dy;
        longint dz;
        longint s;
        dx = longint'(qx) - longint'(pts_x[q]);
        dy = longint'(qy) - longint'(pts_y[q]);
        dz = longint'(qz) - longint'(pts_z[q]);
        if (cur_metric == METRIC_MOD_MANHATTAN)
        begin
            s = dx + dy + dz;
            return 36'((s < 0) ? -s : s);
        end
        if (cur_metric == METRIC_EUCLIDEAN)
            return 36'(dx * dx + dy * dy + dz * dz);
        return 36'(((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy) + ((dz < 0) ? -dz : dz));
    endfunction

    task automatic predict_item(input logic op, input logic [9:0] pidx, input logic [9:0] qid,
                                input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic signed [15:0] z);
        logic [35:0] bd [MAX_NEIGHBORS];
        logic [9:0]  bi [MAX_NEIGHBORS];
        logic [35:0] d;
        int n;
        int k;
        int pos;
        nbr_beat_t b;
        if (op == OP_LOAD)
        begin
            pts_x[pidx] = x;
            pts_y[pidx] = y;
            pts_z[pidx] = z;
            return;
        end
        n = (cur_nref > STORE_DEPTH) ? STORE_DEPTH : cur_nref;
        k = (cur_k > MAX_NEIGHBORS) ? MAX_NEIGHBORS : cur_k;
        if (k > n)
            k = n;
        for (int i = 0; i < MAX_NEIGHBORS; i++)
        begin
            bd[i] = DIST_MAX;
            bi[i] = '0;
        end
        for (int j = 0; j < n; j++)
        begin
            d = point_distance(j, x, y, z);
            pos = 0;
            while (pos < k && bd[pos] <= d)
                pos++;
            if (pos < k)
            begin
                for (int i = k - 1; i > pos; i--)
                begin
                    bd[i] = bd[i-1];
                    bi[i] = bi[i-1];
                end
                bd[pos] = d;
                bi[pos] = j[9:0];
            end
        end
        for (int j = 0; j < k; j++)
        begin
            b.nbr = bi[j];
            b.rnk = j[3:0];
            b.tag = qid;
            b.lst = (j == k - 1);
            expected_beats = {expected_beats, b};
        end
    endtask

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(99) < 29);
    endfunction

    // send one beat; predictor runs in order of acceptance
    task automatic send_item(input logic op, input logic [9:0] pidx, input logic [9:0] qid,
                             input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        load_addr   <= pidx;
        query_id    <= qid;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(op, pidx, qid, x, y, z);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        // a trailing load can still be in flight
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_METRIC)
            cur_metric = val[1:0];
        else if (idx == CFG_NEIGHBORS)
            cur_k = val[4:0];
        else if (idx == CFG_NUM_REF)
            cur_nref = val;
    endtask

    task automatic setup(input logic [1:0] m, input logic [4:0] k, input logic [10:0] n);
        wait_drained();
        write_reg(CFG_METRIC, {9'd0, m});
        write_reg(CFG_NEIGHBORS, {6'd0, k});
        write_reg(CFG_NUM_REF, n);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_coord(input bit narrow);
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return narrow ? 16'(signed'($urandom_range(40)) - 20) : 16'($urandom);
        endcase
    endfunction

    task automatic load_random(input int cnt, input bit narrow);
        for (int i = 0; i < cnt; i++)
            send_item(OP_LOAD, i[9:0], 10'($urandom), rand_coord(narrow), rand_coord(narrow),
                      rand_coord(narrow));
    endtask

    task automatic query_random(input bit narrow);
        send_item(OP_QUERY, 10'($urandom), 10'($urandom), rand_coord(narrow),
                  rand_coord(narrow), rand_coord(narrow));
    endtask

    // checker and output stall
    always @(posedge clk)
    begin
        nbr_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                e = expected_beats.pop_front();
                if (neighbor_index !== e.nbr)
                    report_mismatch($sformatf("neighbor_index %0d exp %0d", neighbor_index,
                                              e.nbr));
                if (rank !== e.rnk)
                    report_mismatch($sformatf("rank %0d exp %0d", rank, e.rnk));
                if (result_tag !== e.tag)
                    report_mismatch($sformatf("result_tag %0d exp %0d", result_tag, e.tag));
                if (last !== e.lst)
                    report_mismatch($sformatf("last %0b exp %0b", last, e.lst));
            end
        end
        out_stall <= take_gap();
    end

    task automatic test_extremes();
        setup(METRIC_EUCLIDEAN, 5'd16, 11'd16);
        send_item(OP_LOAD, 10'd0, 10'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(OP_LOAD, 10'd1, 10'd0, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(OP_LOAD, 10'd1023, 10'h3ff, 16'sh0000, 16'sh0000, 16'sh0000);
        for (int i = 2; i < 16; i++)
            send_item(OP_LOAD, i[9:0], 10'd0, 16'(i), -16'(i), 16'sd0);
        // duplicate of point 2 gives a tie
        send_item(OP_LOAD, 10'd3, 10'd0, 16'sd2, -16'sd2, 16'sd0);
        send_item(OP_QUERY, 10'h3ff, 10'h3ff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_item(OP_QUERY, 10'd0, 10'd0, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_item(OP_QUERY, 10'd0, 10'h155, 16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_metrics();
        for (int m = 0; m < 4; m++)
        begin
            setup(m[1:0], 5'd5, 11'd16);
            query_random(1'b1);
            query_random(1'b0);
        end
    endtask

    task automatic test_k_limits();
        setup(METRIC_MANHATTAN, 5'd0, 11'd16);
        query_random(1'b1);
        setup(METRIC_MANHATTAN, 5'd31, 11'd16);
        query_random(1'b1);
        setup(METRIC_MANHATTAN, 5'd8, 11'd0);
        query_random(1'b1);
        setup(METRIC_MANHATTAN, 5'd8, 11'd3);
        query_random(1'b1);
        setup(METRIC_EUCLIDEAN, 5'd1, 11'd1);
        query_random(1'b1);
    endtask

    task automatic test_random_mix();
        int n;
        for (int ph = 0; ph < 12; ph++)
        begin
            n = $urandom_range(1, 20);
            setup(2'($urandom), 5'($urandom_range(0, 20)), 11'(n));
            no_idle = (ph == 5);
            load_random(n, ph[0]);
            for (int i = 0; i < 10; i++)
            begin
                // reload a few points between queries, within the searched range
                if ($urandom_range(2) == 0)
                    send_item(OP_LOAD, 10'($urandom_range(n - 1)), 10'($urandom),
                              rand_coord(ph[0]), rand_coord(ph[0]), rand_coord(ph[0]));
                query_random(ph[0]);
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        error_count = 0;
        no_idle     = 1'b0;
        cur_metric  = METRIC_EUCLIDEAN;
        cur_k       = 5'd1;
        cur_nref    = 11'd1024;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_LOAD;
        load_addr   = '0;
        query_id    = '0;
        coord_x     = '0;
        coord_y     = '0;
        coord_z     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_METRIC;
        cfg_data    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_metrics();
        test_k_limits();
        test_random_mix();

        wait_drained();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
